// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the given reset is low.
`define ASSERT_CLKED(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of the enclosing module.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKED(label, clk_i, rst_ni, prop, msg)

`endif

// File: sv/dnsp_pkg.sv
// Package of the decimal number stream parser: widths, characters, types.
`default_nettype none

package dnsp_pkg;

  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned SIG_W          = 60;
  localparam int unsigned FRAC_W         = 5;
  localparam int unsigned DEF_MAX_DIGITS = 18;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic KIND_NUMBER = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_INT  = 3'b010,
    PH_FRAC = 3'b100
  } phase_e;

  typedef struct packed {
    logic              kind;
    logic              negative;
    logic [SIG_W-1:0]  significand;
    logic [FRAC_W-1:0] fraction_digits;
    logic [CHAR_W-1:0] terminator;
    logic              ended_by_end;
    logic              overflow;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: sv/dnsp_char_if.sv
// Input channel: one character or end mark per transfer.
`default_nettype none

interface dnsp_char_if import dnsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_end;

  modport source (output valid, output character, output is_end, input ready);
  modport sink   (input valid, input character, input is_end, output ready);
endinterface

`default_nettype wire

// File: sv/dnsp_res_if.sv
// Result channel: one parsed number or rejected character per transfer.
`default_nettype none

interface dnsp_res_if import dnsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic              negative;
  logic [SIG_W-1:0]  significand;
  logic [FRAC_W-1:0] fraction_digits;
  logic [CHAR_W-1:0] terminator;
  logic              ended_by_end;
  logic              overflow;
  logic              last;

  modport source (
    output valid, output kind, output negative, output significand,
    output fraction_digits, output terminator, output ended_by_end,
    output overflow, output last, input ready
  );
  modport sink (
    input valid, input kind, input negative, input significand,
    input fraction_digits, input terminator, input ended_by_end,
    input overflow, input last, output ready
  );
endinterface

`default_nettype wire

// File: sv/dnsp_parse.sv
// Parser state registers and the single-pass step logic for one character.
`default_nettype none

module dnsp_parse import dnsp_pkg::*; #(
  parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [CHAR_W-1:0] character_i,
  input  wire logic              is_end_i,
  output logic [1:0]             n_res_o,
  output res_t                   res0_o,
  output res_t                   res1_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned PROD_W = SIG_W + 4;

  phase_e             phase_q, phase_d;
  logic               minus_q, minus_d;
  logic [SIG_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   frac_q, frac_d;
  logic [CNT_W-1:0]   dcnt_q, dcnt_d;
  logic               ovf_q, ovf_d;

  logic               is_dig, is_sp, is_sign, idle_rej, in_frac, skip, refuse;
  logic [3:0]         dval;
  logic [PROD_W-1:0]  prod;
  phase_e             phase_idle;
  logic [SIG_W-1:0]   acc_idle;
  logic [CNT_W-1:0]   dcnt_idle;
  res_t               num_res, rej_res;

  always_comb begin
    is_dig  = (character_i >= CH_ZERO) && (character_i <= CH_NINE);
    is_sp   = ((character_i >= CH_TAB) && (character_i <= CH_CR)) ||
              (character_i == CH_SPACE);
    is_sign = (character_i == CH_PLUS) || (character_i == CH_MINUS);
    dval    = character_i[3:0];
    idle_rej = !is_sp && !is_dig && !is_sign;

    // Outcome of handling the character from a cleared state.
    phase_idle = (is_dig || is_sign) ? PH_INT : PH_IDLE;
    acc_idle   = is_dig ? SIG_W'(dval) : '0;
    dcnt_idle  = (is_dig && (dval != 4'd0)) ? CNT_W'(1) : '0;

    // Multiply by ten as two shifted copies; the top bits flag a significand
    // that would not fit.
    in_frac = (phase_q == PH_FRAC);
    prod    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + PROD_W'(dval);
    skip    = !in_frac && (acc_q == '0) && (dval == 4'd0);
    refuse  = (dcnt_q >= CNT_W'(MAX_DIGITS)) || (prod[PROD_W-1:SIG_W] != '0);

    num_res.kind            = KIND_NUMBER;
    num_res.negative        = minus_q;
    num_res.significand     = acc_q;
    num_res.fraction_digits = FRAC_W'(frac_q);
    num_res.terminator      = is_end_i ? '0 : character_i;
    num_res.ended_by_end    = is_end_i;
    num_res.overflow        = ovf_q;
    num_res.last            = 1'b1;

    rej_res                 = '0;
    rej_res.kind            = KIND_REJECT;
    rej_res.terminator      = character_i;
    rej_res.last            = 1'b1;

    phase_d = phase_q;
    minus_d = minus_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    dcnt_d  = dcnt_q;
    ovf_d   = ovf_q;
    n_res_o = 2'd0;
    res0_o  = num_res;
    res1_o  = rej_res;

    if (is_end_i) begin
      n_res_o = 2'd1;
      phase_d = PH_IDLE;
      minus_d = 1'b0;
      acc_d   = '0;
      frac_d  = '0;
      dcnt_d  = '0;
      ovf_d   = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          phase_d = phase_idle;
          minus_d = (character_i == CH_MINUS);
          acc_d   = acc_idle;
          dcnt_d  = dcnt_idle;
          if (idle_rej) begin
            n_res_o = 2'd1;
            res0_o  = rej_res;
          end
        end
        PH_INT, PH_FRAC: begin
          if (is_dig) begin
            if (!skip) begin
              if (refuse) begin
                ovf_d = 1'b1;
              end else begin
                acc_d  = prod[SIG_W-1:0];
                dcnt_d = dcnt_q + CNT_W'(1);
                if (in_frac) begin
                  frac_d = frac_q + CNT_W'(1);
                end
              end
            end
          end else if ((character_i == CH_POINT) && !in_frac) begin
            phase_d = PH_FRAC;
          end else begin
            // The terminator starts the next parse from a cleared state.
            n_res_o     = idle_rej ? 2'd2 : 2'd1;
            res0_o.last = !idle_rej;
            phase_d     = phase_idle;
            minus_d     = (character_i == CH_MINUS);
            acc_d       = acc_idle;
            frac_d      = '0;
            dcnt_d      = dcnt_idle;
            ovf_d       = 1'b0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          minus_d = 1'b0;
          acc_d   = '0;
          frac_d  = '0;
          dcnt_d  = '0;
          ovf_d   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      minus_q <= 1'b0;
      acc_q   <= '0;
      frac_q  <= '0;
      dcnt_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      minus_q <= minus_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      dcnt_q  <= dcnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/dnsp_out_q.sv
// Two-entry result queue: takes up to two results a cycle, hands out one while ready_i is high.
`default_nettype none

module dnsp_out_q import dnsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_n_i,
  input  wire res_t       r0_i,
  input  wire res_t       r1_i,
  input  wire logic       ready_i,
  output logic            valid_o,
  output res_t            head_o,
  output logic [1:0]      free_o
);

  logic [1:0] cnt_q, cnt_d, cnt_a;
  res_t       s0_q, s0_d, s1_q, s1_d, a0;
  logic       pop;

  always_comb begin
    valid_o = (cnt_q != 2'd0);
    head_o  = s0_q;
    pop     = valid_o && ready_i;
    cnt_a   = cnt_q - {1'b0, pop};
    a0      = pop ? s1_q : s0_q;
    // Room left once this cycle's transfer out has been taken into account.
    free_o  = 2'd2 - cnt_a;
    cnt_d   = cnt_a + push_n_i;
    if (cnt_a == 2'd0) begin
      s0_d = r0_i;
      s1_d = r1_i;
    end else if (cnt_a == 2'd1) begin
      s0_d = a0;
      s1_d = r0_i;
    end else begin
      // Full and nothing left: both entries keep what they hold.
      s0_d = s0_q;
      s1_d = s1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

`default_nettype wire

// File: sv/decimal_number_stream_parser.sv
// Top level of the decimal number stream parser.
//
//   channel   direction   payload
//   char_i    in          character, is_end
//   res_o     out         kind, negative, significand, fraction_digits,
//                         terminator, ended_by_end, overflow, last
//
// One character is taken per cycle unless the parser stalls: it lands in the
// input register, and once its results fit the queue the step logic updates
// the parser state and pushes them into a two-entry queue that drives res_o.
// A character that ends a number and is itself rejected gives two results,
// which leave one per cycle while res_o.ready is high; the input register then
// waits for queue room. Reset clears the parser to idle and empties the queue.
// A stall on res_o reaches char_i.ready once held results cannot fit the queue.
`default_nettype none

module decimal_number_stream_parser import dnsp_pkg::*; #(
  parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dnsp_char_if.sink    char_i,
  dnsp_res_if.source   res_o
);

  logic              inq_valid_q, inq_valid_d;
  logic [CHAR_W-1:0] inq_char_q;
  logic              inq_end_q;
  logic              accept, consume;
  logic [1:0]        n_res, free, push_n;
  res_t              res0, res1, head;

  dnsp_parse #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (consume),
    .character_i (inq_char_q),
    .is_end_i    (inq_end_q),
    .n_res_o     (n_res),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  dnsp_out_q u_out_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .r0_i     (res0),
    .r1_i     (res1),
    .ready_i  (res_o.ready),
    .valid_o  (res_o.valid),
    .head_o   (head),
    .free_o   (free)
  );

  // The held character is handled only when all its results fit the queue.
  assign consume      = inq_valid_q && (n_res <= free);
  assign push_n       = consume ? n_res : 2'd0;
  assign char_i.ready = !inq_valid_q || consume;
  assign accept       = char_i.valid && char_i.ready;
  assign inq_valid_d  = accept || (inq_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inq_char_q <= char_i.character;
      inq_end_q  <= char_i.is_end;
    end
  end

  assign res_o.kind            = head.kind;
  assign res_o.negative        = head.negative;
  assign res_o.significand     = head.significand;
  assign res_o.fraction_digits = head.fraction_digits;
  assign res_o.terminator      = head.terminator;
  assign res_o.ended_by_end    = head.ended_by_end;
  assign res_o.overflow        = head.overflow;
  assign res_o.last            = head.last;

endmodule

`default_nettype wire

// File: sv/dnsp_checker.sv
// Port-level checks on the result channel of the parser, bound to the top.
`default_nettype none
`include "assert_macros.svh"

module dnsp_checker import dnsp_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              valid_i,
  input wire logic              ready_i,
  input wire logic              kind_i,
  input wire logic              negative_i,
  input wire logic [SIG_W-1:0]  significand_i,
  input wire logic [FRAC_W-1:0] fraction_digits_i,
  input wire logic [CHAR_W-1:0] terminator_i,
  input wire logic              ended_by_end_i,
  input wire logic              overflow_i,
  input wire logic              last_i
);

  `ASSERT_STD(a_res_hold, valid_i && !ready_i |=> valid_i && $stable(significand_i) && $stable(terminator_i) && $stable(kind_i) && $stable(last_i), "stalled result changed")

  `ASSERT_STD(a_reject_clean, valid_i && (kind_i == KIND_REJECT) |-> !negative_i && (significand_i == '0) && (fraction_digits_i == '0) && !ended_by_end_i && !overflow_i && last_i, "rejected result carries number fields")

  `ASSERT_STD(a_end_result, valid_i && ended_by_end_i |-> (kind_i == KIND_NUMBER) && (terminator_i == '0) && last_i, "end mark result malformed")

  `ASSERT_STD(a_first_of_two, valid_i && !last_i |-> (kind_i == KIND_NUMBER) && !ended_by_end_i, "non-final result is not a character-ended number")

endmodule

bind decimal_number_stream_parser dnsp_checker u_dnsp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .valid_i           (res_o.valid),
  .ready_i           (res_o.ready),
  .kind_i            (res_o.kind),
  .negative_i        (res_o.negative),
  .significand_i     (res_o.significand),
  .fraction_digits_i (res_o.fraction_digits),
  .terminator_i      (res_o.terminator),
  .ended_by_end_i    (res_o.ended_by_end),
  .overflow_i        (res_o.overflow),
  .last_i            (res_o.last)
);

`default_nettype wire
